// File: src/websocket_frame_deframer_defines.svh
// Assertion macros shared by the deframer RTL
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Invariant that holds at every clock edge out of reset
`define WSD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define WSD_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: src/wsd_pkg.sv
// Types and constants of the frame deframer
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [7:0] ERR_MASKED = 8'd0;
  localparam logic [7:0] ERR_CONT   = 8'd1;

  localparam logic [7:0] PONG_HDR  = 8'h8A;
  localparam logic [7:0] CLOSE_HDR = 8'h88;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// File: src/websocket_frame_deframer.sv
// Frame deframer: parses received bytes and queues message, reply and error items
//
// Usage:
//   in_*  : one received byte per item (in_tdata). Taken whenever in_tvalid
//           and in_tready are high.
//   out_* : one result per item. out_tuser is the result kind (message byte,
//           empty message end, reply byte, error), out_tdata the byte or the
//           error code, out_tlast the end of a message or of a reply frame.
//   A byte is parsed in the cycle it is taken and its results (zero, one or
//   two) are written to a four-entry result queue, whose head drives out_*.
//   One byte is taken every cycle as long as the queue holds at most two
//   items, so a steady stream runs at one byte per cycle; only a ping or
//   close reply adds an extra item to drain.
//   When the receiver stalls, the queue fills and in_tready drops until it
//   has room for two more items. Reset (rst_n low at a clock edge) empties
//   the queue and returns the parser to the first header byte with no
//   message open.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast   // out_last
);

  localparam int unsigned PW = $clog2(wsd_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(wsd_pkg::QDEPTH + 1);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  ebc_r, ebc_nxt;
  logic [63:0] br_r, br_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  msg_r, msg_nxt;

  logic        fin_ev, fin_empty, err_ev, txt_ev, txt_last;
  logic [7:0]  err_code;

  wsd_pkg::res_t res0, res1;
  logic [1:0]    res_n;

  wsd_pkg::res_t q_r [wsd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          in_hs, out_hs;

  assign in_hs  = in_tvalid && in_tready;
  assign out_hs = out_tvalid && out_tready;

  // Parser next state
  always_comb begin
    logic [6:0] len7;
    logic       len_done;
    logic       start;
    logic [3:0] eff;
    len7       = in_tdata[6:0];
    len_done   = 1'b0;
    start      = 1'b0;
    eff        = kind_r;
    phase_nxt  = phase_r;
    ebc_nxt    = ebc_r;
    br_nxt     = br_r;
    final_nxt  = final_r;
    kind_nxt   = kind_r;
    masked_nxt = masked_r;
    msg_nxt    = msg_r;
    fin_ev     = 1'b0;
    fin_empty  = 1'b0;
    err_ev     = 1'b0;
    err_code   = wsd_pkg::ERR_MASKED;
    txt_ev     = 1'b0;
    txt_last   = 1'b0;
    case (phase_r)
      wsd_pkg::PH_HDR1: begin
        masked_nxt = in_tdata[7];
        if (len7 == wsd_pkg::LEN_EXT16) begin
          br_nxt    = '0;
          ebc_nxt   = 3'd1;
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else if (len7 == wsd_pkg::LEN_EXT64) begin
          br_nxt    = '0;
          ebc_nxt   = 3'd7;
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else begin
          br_nxt   = {57'd0, len7};
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        br_nxt = {br_r[55:0], in_tdata};
        if (ebc_r == 3'd0) begin
          len_done = 1'b1;
        end else begin
          ebc_nxt = ebc_r - 3'd1;
        end
      end
      wsd_pkg::PH_MASK: begin
        if (ebc_r == 3'd0) begin
          start = 1'b1;
        end else begin
          ebc_nxt = ebc_r - 3'd1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        br_nxt = br_r - 64'd1;
        if (kind_r == wsd_pkg::OP_TEXT) begin
          txt_ev   = 1'b1;
          txt_last = final_r && (br_nxt == 64'd0);
        end
        if (br_nxt == 64'd0) begin
          fin_ev = 1'b1;
        end
      end
      default: begin
        final_nxt = in_tdata[7];
        kind_nxt  = in_tdata[3:0];
        phase_nxt = wsd_pkg::PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (masked_nxt) begin
        ebc_nxt   = 3'd3;
        phase_nxt = wsd_pkg::PH_MASK;
      end else begin
        start = 1'b1;
      end
    end

    if (start) begin
      if (masked_nxt) begin
        err_ev   = 1'b1;
        err_code = wsd_pkg::ERR_MASKED;
        kind_nxt = wsd_pkg::OP_CONT;
      end else if (kind_nxt == wsd_pkg::OP_CONT && msg_r == 4'd0) begin
        err_ev   = 1'b1;
        err_code = wsd_pkg::ERR_CONT;
        kind_nxt = wsd_pkg::OP_CONT;
      end else if (kind_nxt == wsd_pkg::OP_CONT || kind_nxt == wsd_pkg::OP_TEXT ||
                   kind_nxt == wsd_pkg::OP_BIN) begin
        eff      = (msg_r != 4'd0) ? msg_r : kind_nxt;
        msg_nxt  = final_nxt ? 4'd0 : eff;
        kind_nxt = eff;
      end else if (kind_nxt < wsd_pkg::OP_CLOSE) begin
        kind_nxt = wsd_pkg::OP_CONT;
      end
      if (br_nxt == 64'd0) begin
        fin_ev    = 1'b1;
        fin_empty = 1'b1;
      end else begin
        phase_nxt = wsd_pkg::PH_PAYLOAD;
      end
    end

    if (fin_ev) begin
      phase_nxt = wsd_pkg::PH_HDR0;
    end
  end

  // Result items for the current byte
  always_comb begin
    res0  = '{kind: wsd_pkg::KIND_MSG, data: in_tdata, last: txt_last};
    res1  = '{kind: wsd_pkg::KIND_REPLY, data: 8'h00, last: 1'b1};
    res_n = 2'd0;
    if (err_ev) begin
      res0  = '{kind: wsd_pkg::KIND_ERR, data: err_code, last: 1'b0};
      res_n = 2'd1;
    end else if (txt_ev) begin
      res_n = 2'd1;
    end
    if (fin_ev) begin
      if (kind_nxt == wsd_pkg::OP_TEXT && final_nxt && fin_empty) begin
        res0  = '{kind: wsd_pkg::KIND_END, data: 8'h00, last: 1'b1};
        res_n = 2'd1;
      end else if (kind_nxt == wsd_pkg::OP_PING) begin
        res0  = '{kind: wsd_pkg::KIND_REPLY, data: wsd_pkg::PONG_HDR, last: 1'b0};
        res_n = 2'd2;
      end else if (kind_nxt == wsd_pkg::OP_CLOSE) begin
        res0  = '{kind: wsd_pkg::KIND_REPLY, data: wsd_pkg::CLOSE_HDR, last: 1'b0};
        res_n = 2'd2;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_hs) begin
      count_nxt = count_nxt + CW'(res_n);
    end
    if (out_hs) begin
      count_nxt = count_nxt - CW'(1);
    end
  end

  assign in_tready  = (count_r <= CW'(wsd_pkg::QDEPTH - 2));
  assign out_tvalid = (count_r != '0);
  assign out_tuser  = q_r[rd_ptr_r].kind;
  assign out_tdata  = q_r[rd_ptr_r].data;
  assign out_tlast  = q_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      ebc_r    <= '0;
      br_r     <= '0;
      final_r  <= 1'b0;
      kind_r   <= '0;
      masked_r <= 1'b0;
      msg_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_hs) begin
        phase_r  <= phase_nxt;
        ebc_r    <= ebc_nxt;
        br_r     <= br_nxt;
        final_r  <= final_nxt;
        kind_r   <= kind_nxt;
        masked_r <= masked_nxt;
        msg_r    <= msg_nxt;
        wr_ptr_r <= wr_ptr_r + PW'(res_n);
      end
      if (out_hs) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs && res_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_hs && res_n == 2'd2) begin
      q_r[wr_ptr_r + PW'(1)] <= res1;
    end
  end

`include "websocket_frame_deframer_defines.svh"

  `WSD_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(wsd_pkg::QDEPTH), "result queue overflow")
  `WSD_ASSERT_ALWAYS(a_payload_len, phase_r != wsd_pkg::PH_PAYLOAD || br_r != 64'd0, "payload phase with no bytes left")
  `WSD_ASSERT_ALWAYS(a_mask_cnt, phase_r != wsd_pkg::PH_MASK || ebc_r <= 3'd3, "mask key count out of range")
  `WSD_ASSERT_ALWAYS(a_msg_kind, msg_r == 4'd0 || msg_r == wsd_pkg::OP_TEXT || msg_r == wsd_pkg::OP_BIN, "bad open message kind")
  `WSD_ASSERT_NEXT(a_drain, out_hs && !in_hs, count_r == $past(count_r) - CW'(1), "queue count not reduced on drain")

endmodule
